// ===== design/lps_pkg.sv =====
// Shared types and constants for the LED pattern sequencer.
package lps_pkg;

    localparam int INTERVAL_W    = 16;
    localparam int NUM_INTERVALS = 4;
    localparam int ELAPSED_W     = 18;
    localparam int SEED_W        = 16;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Command codes
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_NEXT   = 3'd1;
    localparam logic [2:0] OP_FASTER = 3'd2;
    localparam logic [2:0] OP_SLOWER = 3'd3;
    localparam logic [2:0] OP_SET    = 3'd4;
    localparam logic [2:0] OP_SHOW   = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_INTERVAL0 = 3'd0;
    localparam logic [2:0] CFG_INTERVAL1 = 3'd1;
    localparam logic [2:0] CFG_INTERVAL2 = 3'd2;
    localparam logic [2:0] CFG_INTERVAL3 = 3'd3;
    localparam logic [2:0] CFG_SEED      = 3'd4;

    // Pattern modes
    localparam logic [1:0] MODE_COLOUR = 2'd0;
    localparam logic [1:0] MODE_CHASE  = 2'd1;
    localparam logic [1:0] MODE_BOUNCE = 2'd2;
    localparam logic [1:0] MODE_RANDOM = 2'd3;

    // Colour phases
    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_GREEN = 2'd1;
    localparam logic [1:0] PHASE_BLUE  = 2'd2;

    localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

    typedef logic [NUM_INTERVALS-1:0][INTERVAL_W-1:0] interval_set_t;

    localparam interval_set_t INTERVAL_RESET = {16'd100, 16'd250, 16'd500, 16'd1000};

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] speed_value;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] leds;
        logic [1:0] mode;
        logic [1:0] speed_level;
        logic       bad_speed;
        logic       stepped;
    } res_item_t;

    typedef struct packed {
        logic              load;
        logic [SEED_W-1:0] value;
    } seed_load_t;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        return (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
    endfunction

endpackage

// ===== design/lps_cfg.sv =====
// Configuration registers: step intervals and LFSR seed loading.
module lps_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic [2:0]                 cfg_index,
    input  logic [15:0]                cfg_data,
    output lps_pkg::interval_set_t     intervals,
    output lps_pkg::seed_load_t        seed_load
);

    lps_pkg::interval_set_t intervals_reg;
    lps_pkg::interval_set_t intervals_next;

    always_comb
    begin
        intervals_next = intervals_reg;
        seed_load.load = 1'b0;
        seed_load.value = (cfg_data == '0) ? 16'd1 : cfg_data;
        if (cfg_valid)
        begin
            unique case (cfg_index) inside
                lps_pkg::CFG_INTERVAL0, lps_pkg::CFG_INTERVAL1,
                lps_pkg::CFG_INTERVAL2, lps_pkg::CFG_INTERVAL3:
                    intervals_next[cfg_index[1:0]] = cfg_data;
                lps_pkg::CFG_SEED:
                    seed_load.load = 1'b1;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            intervals_reg <= lps_pkg::INTERVAL_RESET;
        else
            intervals_reg <= intervals_next;
    end

    assign intervals = intervals_reg;

endmodule

// ===== design/lps_pattern.sv =====
// Next-step logic of the four LED patterns.
module lps_pattern #(
    parameter int NUM_LEDS = 8
)
(
    input  logic [1:0]                    mode,
    input  logic [NUM_LEDS-1:0]           led_mask,
    input  logic [1:0]                    colour_phase,
    input  logic [$clog2(NUM_LEDS)-1:0]   chase_pos,
    input  logic [$clog2(NUM_LEDS)-1:0]   bounce_pos,
    input  logic                          bounce_dir,
    input  logic [15:0]                   lfsr,
    output logic [NUM_LEDS-1:0]           led_mask_step,
    output logic [1:0]                    colour_phase_step,
    output logic [$clog2(NUM_LEDS)-1:0]   chase_pos_step,
    output logic [$clog2(NUM_LEDS)-1:0]   bounce_pos_step,
    output logic                          bounce_dir_step,
    output logic [15:0]                   lfsr_step_val
);

    localparam int LW        = $clog2(NUM_LEDS);
    localparam int MOD_SHIFT = 16 + LW;
    localparam int MOD_MUL   = ((1 << MOD_SHIFT) + NUM_LEDS - 1) / NUM_LEDS;
    localparam int MOD_MW    = 18;
    localparam int MOD_PW    = 16 + MOD_MW;

    logic [NUM_LEDS-1:0] grp0;
    logic [NUM_LEDS-1:0] grp1;
    logic [NUM_LEDS-1:0] grp2;
    logic [15:0]         rnd_a;
    logic [15:0]         rnd_b;
    logic [LW-1:0]       chase_adv;

    for (genvar i = 0; i < NUM_LEDS; i++)
    begin : g_grp
        assign grp0[i] = ((i % 3) == 0);
        assign grp1[i] = ((i % 3) == 1);
        assign grp2[i] = ((i % 3) == 2);
    end

    // Exact reciprocal-multiply remainder for 16-bit values
    function automatic logic [LW-1:0] mod_leds(input logic [15:0] v);
        logic [MOD_PW-1:0] prod;
        logic [15:0]       q;
        logic [15:0]       r;
        prod = {{(MOD_PW-16){1'b0}}, v} * MOD_PW'(MOD_MUL);
        q = 16'(prod >> MOD_SHIFT);
        r = v - 16'(q * 16'(NUM_LEDS));
        return r[LW-1:0];
    endfunction

    function automatic logic [NUM_LEDS-1:0] led_bit(input logic [LW-1:0] p);
        return NUM_LEDS'(1) << p;
    endfunction

    assign rnd_a     = lps_pkg::lfsr_step(lfsr);
    assign rnd_b     = lps_pkg::lfsr_step(rnd_a);
    assign chase_adv = (chase_pos >= LW'(NUM_LEDS - 1)) ? '0 : chase_pos + LW'(1);

    always_comb
    begin
        led_mask_step     = led_mask;
        colour_phase_step = colour_phase;
        chase_pos_step    = chase_pos;
        bounce_pos_step   = bounce_pos;
        bounce_dir_step   = bounce_dir;
        lfsr_step_val     = lfsr;
        case (mode)
            lps_pkg::MODE_COLOUR:
            begin
                case (colour_phase)
                    lps_pkg::PHASE_GREEN:
                    begin
                        led_mask_step     = (led_mask | grp1) & ~grp0;
                        colour_phase_step = lps_pkg::PHASE_BLUE;
                    end
                    lps_pkg::PHASE_BLUE:
                    begin
                        led_mask_step     = (led_mask | grp2) & ~grp1;
                        colour_phase_step = lps_pkg::PHASE_RED;
                    end
                    default:
                    begin
                        led_mask_step     = (led_mask | grp0) & ~grp2;
                        colour_phase_step = lps_pkg::PHASE_GREEN;
                    end
                endcase
            end
            lps_pkg::MODE_CHASE:
            begin
                chase_pos_step = chase_adv;
                led_mask_step  = (led_mask & ~led_bit(chase_pos)) | led_bit(chase_adv);
            end
            lps_pkg::MODE_BOUNCE:
            begin
                if (bounce_dir)
                begin
                    if (bounce_pos >= LW'(NUM_LEDS - 1))
                    begin
                        bounce_dir_step = 1'b0;
                        bounce_pos_step = LW'(NUM_LEDS - 2);
                    end
                    else
                        bounce_pos_step = bounce_pos + LW'(1);
                end
                else
                begin
                    if (bounce_pos == '0)
                    begin
                        bounce_dir_step = 1'b1;
                        bounce_pos_step = LW'(1);
                    end
                    else
                        bounce_pos_step = bounce_pos - LW'(1);
                end
                led_mask_step = (led_mask & ~led_bit(bounce_pos)) | led_bit(bounce_pos_step);
            end
            default:
            begin
                lfsr_step_val = rnd_b;
                led_mask_step = (led_mask | led_bit(mod_leds(rnd_a))) & ~led_bit(mod_leds(rnd_b));
            end
        endcase
    end

endmodule

// ===== design/led_pattern_sequencer.sv =====
// Top level of the LED pattern sequencer.
//
// Channels: commands enter on cmd/cmd_valid/cmd_stall, one result per command
// leaves on res/res_valid/res_stall. A transfer happens at a rising edge with
// valid high and stall low. Configuration writes use cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high and writes belong in idle
// periods. Writing the seed register reloads the LFSR (zero loads as one).
// A transferred command waits in the command register; its result is computed
// from it and held in the result register, which drives res.
// Throughput: one command per cycle while res_stall holds no result, set by the
// single state-update stage between the command register and the result register.
// When res_stall holds a result, the command register keeps its item and
// cmd_stall rises only while that register is full and cannot move on.
// Reset: asynchronous, active low; all LEDs off, colour mode, speed level 0,
// intervals 1000/500/250/100 ms, LFSR loaded with the default seed.
module led_pattern_sequencer #(
    parameter int NUM_LEDS     = 8,
    parameter int SPEED_LEVELS = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  lps_pkg::cmd_item_t   cmd,
    output logic                 res_valid,
    input  logic                 res_stall,
    output lps_pkg::res_item_t   res,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int LW            = $clog2(NUM_LEDS);
    localparam int USABLE_LEVELS = (SPEED_LEVELS < 4) ? SPEED_LEVELS : 4;
    localparam int EW            = lps_pkg::ELAPSED_W;

    lps_pkg::interval_set_t intervals;
    lps_pkg::seed_load_t    seed_load;

    lps_pkg::cmd_item_t  cmd_reg;
    logic                cmd_valid_reg, cmd_valid_next;
    lps_pkg::res_item_t  res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic [NUM_LEDS-1:0] led_mask_reg, led_mask_next;
    logic [1:0]          mode_reg, mode_next;
    logic [1:0]          speed_reg, speed_next;
    logic [EW-1:0]       elapsed_reg, elapsed_next;
    logic [1:0]          phase_reg, phase_next;
    logic [LW-1:0]       chase_reg, chase_next;
    logic [LW-1:0]       bounce_reg, bounce_next;
    logic                dir_reg, dir_next;
    logic [15:0]         lfsr_reg, lfsr_next;

    logic [NUM_LEDS-1:0] led_mask_step;
    logic [1:0]          phase_step;
    logic [LW-1:0]       chase_step;
    logic [LW-1:0]       bounce_step;
    logic                dir_step;
    logic [15:0]         lfsr_step_val;

    logic                advance;
    logic                process;
    logic                take;
    logic [15:0]         interval;
    logic [EW-1:0]       limit;
    logic [EW-1:0]       elapsed_inc;
    logic                do_step;
    logic [NUM_LEDS+7:0] led_ext;

    lps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .intervals (intervals),
        .seed_load (seed_load)
    );

    lps_pattern #(
        .NUM_LEDS (NUM_LEDS)
    ) u_pattern (
        .mode              (mode_reg),
        .led_mask          (led_mask_reg),
        .colour_phase      (phase_reg),
        .chase_pos         (chase_reg),
        .bounce_pos        (bounce_reg),
        .bounce_dir        (dir_reg),
        .lfsr              (lfsr_reg),
        .led_mask_step     (led_mask_step),
        .colour_phase_step (phase_step),
        .chase_pos_step    (chase_step),
        .bounce_pos_step   (bounce_step),
        .bounce_dir_step   (dir_step),
        .lfsr_step_val     (lfsr_step_val)
    );

    assign cfg_ready = 1'b1;
    assign advance   = !res_valid_reg || !res_stall;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign take      = cmd_valid && !cmd_stall;
    assign process   = cmd_valid_reg && advance;

    assign interval    = intervals[speed_reg];
    assign limit       = (mode_reg == lps_pkg::MODE_COLOUR)
                         ? ({1'b0, interval, 1'b0} + {2'b00, interval})
                         : {1'b0, interval, 1'b0};
    assign elapsed_inc = (elapsed_reg == lps_pkg::ELAPSED_MAX)
                         ? elapsed_reg : elapsed_reg + EW'(1);
    assign do_step     = (cmd_reg.op == lps_pkg::OP_TICK) && (elapsed_inc > limit);

    always_comb
    begin
        cmd_valid_next = take ? 1'b1 : (advance ? 1'b0 : cmd_valid_reg);
        res_valid_next = process || (res_valid_reg && res_stall);

        led_mask_next = led_mask_reg;
        mode_next     = mode_reg;
        speed_next    = speed_reg;
        elapsed_next  = elapsed_reg;
        phase_next    = phase_reg;
        chase_next    = chase_reg;
        bounce_next   = bounce_reg;
        dir_next      = dir_reg;
        lfsr_next     = lfsr_reg;
        res_next      = res_reg;

        if (process)
        begin
            res_next.bad_speed = 1'b0;
            res_next.stepped   = 1'b0;
            unique case (cmd_reg.op)
                lps_pkg::OP_TICK:
                begin
                    if (do_step)
                    begin
                        elapsed_next     = '0;
                        led_mask_next    = led_mask_step;
                        phase_next       = phase_step;
                        chase_next       = chase_step;
                        bounce_next      = bounce_step;
                        dir_next         = dir_step;
                        lfsr_next        = lfsr_step_val;
                        res_next.stepped = 1'b1;
                    end
                    else
                        elapsed_next = elapsed_inc;
                end
                lps_pkg::OP_NEXT:
                begin
                    led_mask_next = '0;
                    mode_next     = mode_reg + 2'd1;
                end
                lps_pkg::OP_FASTER:
                begin
                    if ({1'b0, speed_reg} + 3'd1 < 3'(USABLE_LEVELS))
                        speed_next = speed_reg + 2'd1;
                end
                lps_pkg::OP_SLOWER:
                begin
                    if (speed_reg != 2'd0)
                        speed_next = speed_reg - 2'd1;
                end
                lps_pkg::OP_SET:
                begin
                    if (cmd_reg.speed_value < 8'(USABLE_LEVELS))
                        speed_next = cmd_reg.speed_value[1:0];
                    else
                        res_next.bad_speed = 1'b1;
                end
                default:
                    ;
            endcase
            led_ext              = {8'b0, led_mask_next};
            res_next.leds        = led_ext[7:0];
            res_next.mode        = mode_next;
            res_next.speed_level = speed_next;
        end
        else
            led_ext = {8'b0, led_mask_reg};

        if (seed_load.load)
            lfsr_next = seed_load.value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            led_mask_reg  <= '0;
            mode_reg      <= lps_pkg::MODE_COLOUR;
            speed_reg     <= '0;
            elapsed_reg   <= '0;
            phase_reg     <= lps_pkg::PHASE_RED;
            chase_reg     <= '0;
            bounce_reg    <= '0;
            dir_reg       <= 1'b1;
            lfsr_reg      <= lps_pkg::SEED_RESET;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
            led_mask_reg  <= led_mask_next;
            mode_reg      <= mode_next;
            speed_reg     <= speed_next;
            elapsed_reg   <= elapsed_next;
            phase_reg     <= phase_next;
            chase_reg     <= chase_next;
            bounce_reg    <= bounce_next;
            dir_reg       <= dir_next;
            lfsr_reg      <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd;
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(speed_reg) < USABLE_LEVELS)
        else $error("speed level out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(chase_reg) < NUM_LEDS) && (32'(bounce_reg) < NUM_LEDS))
        else $error("pattern position out of range");

    a_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        process && do_step |=> elapsed_reg == '0)
        else $error("elapsed count not cleared on step");

    a_stepped_tick: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> (!res_reg.stepped || $past(cmd_reg.op) == lps_pkg::OP_TICK))
        else $error("step flagged on a non-tick command");

    a_bad_set: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> (!res_reg.bad_speed || $past(cmd_reg.op) == lps_pkg::OP_SET))
        else $error("bad speed flagged on a non-set command");

    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid_reg && !advance |=> cmd_valid_reg && res_valid_reg)
        else $error("held command lost");

endmodule

// ===== sim/led_pattern_sequencer_tb.sv =====
// Testbench for the LED pattern sequencer: directed and random commands checked against a behavioral predictor.
module led_pattern_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEDS        = 8;
    localparam int USABLE_LEVELS   = 4;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_CMDS      = 100;

    // ops with no defined function behave like show
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    lps_pkg::cmd_item_t  cmd;
    logic                res_valid;
    logic                res_stall;
    lps_pkg::res_item_t  res;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [15:0]         cfg_data;

    led_pattern_sequencer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [15:0]                   step_interval [4];
    logic [7:0]                    led_state;
    logic [1:0]                    pattern_sel;
    logic [1:0]                    speed_sel;
    logic [lps_pkg::ELAPSED_W-1:0] ms_since_step;
    logic [1:0]                    colour_sel;
    logic [2:0]                    chase_pos;
    logic [2:0]                    bounce_pos;
    logic                          bounce_up;
    logic [15:0]                   lfsr_state;

    lps_pkg::res_item_t expected_displays [$];

    bit idle_on;
    int err_count;
    int cmd_count;
    int step_count;
    int config_count;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] led_group(int g);
        logic [7:0] m;
        m = '0;
        for (int i = g; i < NUM_LEDS; i += 3)
            m[i] = 1'b1;
        return m;
    endfunction

    function automatic void reset_predictor();
        step_interval[0] = 16'd1000;
        step_interval[1] = 16'd500;
        step_interval[2] = 16'd250;
        step_interval[3] = 16'd100;
        led_state     = '0;
        pattern_sel   = lps_pkg::MODE_COLOUR;
        speed_sel     = '0;
        ms_since_step = '0;
        colour_sel    = lps_pkg::PHASE_RED;
        chase_pos     = '0;
        bounce_pos    = '0;
        bounce_up     = 1'b1;
        lfsr_state    = lps_pkg::SEED_RESET;
    endfunction

    function automatic logic [15:0] lfsr_advance(logic [15:0] v);
        return {1'b0, v[15:1]} ^ (v[0] ? lps_pkg::LFSR_TAPS : 16'h0000);
    endfunction

    function automatic void advance_pattern();
        case (pattern_sel)
            lps_pkg::MODE_COLOUR:
            begin
                if (colour_sel == lps_pkg::PHASE_GREEN)
                begin
                    led_state  = (led_state | led_group(1)) & ~led_group(0);
                    colour_sel = lps_pkg::PHASE_BLUE;
                end
                else if (colour_sel == lps_pkg::PHASE_BLUE)
                begin
                    led_state  = (led_state | led_group(2)) & ~led_group(1);
                    colour_sel = lps_pkg::PHASE_RED;
                end
                else
                begin
                    led_state  = (led_state | led_group(0)) & ~led_group(2);
                    colour_sel = lps_pkg::PHASE_GREEN;
                end
            end
            lps_pkg::MODE_CHASE:
            begin
                led_state[chase_pos] = 1'b0;
                chase_pos = (int'(chase_pos) < NUM_LEDS - 1) ? chase_pos + 3'd1 : 3'd0;
                led_state[chase_pos] = 1'b1;
            end
            lps_pkg::MODE_BOUNCE:
            begin
                led_state[bounce_pos] = 1'b0;
                if (bounce_up)
                begin
                    if (int'(bounce_pos) + 1 >= NUM_LEDS)
                    begin
                        bounce_up  = 1'b0;
                        bounce_pos = 3'(NUM_LEDS - 2);
                    end
                    else
                        bounce_pos = bounce_pos + 3'd1;
                end
                else
                begin
                    if (bounce_pos == 3'd0)
                    begin
                        bounce_up  = 1'b1;
                        bounce_pos = 3'd1;
                    end
                    else
                        bounce_pos = bounce_pos - 3'd1;
                end
                led_state[bounce_pos] = 1'b1;
            end
            default:
            begin
                lfsr_state = lfsr_advance(lfsr_state);
                led_state[3'(lfsr_state % NUM_LEDS)] = 1'b1;
                lfsr_state = lfsr_advance(lfsr_state);
                led_state[3'(lfsr_state % NUM_LEDS)] = 1'b0;
            end
        endcase
    endfunction

    function automatic lps_pkg::res_item_t next_display(lps_pkg::cmd_item_t c);
        lps_pkg::res_item_t r;
        int                 lim;
        r   = '0;
        lim = ((pattern_sel == lps_pkg::MODE_COLOUR) ? 3 : 2)
              * int'(step_interval[speed_sel]);
        case (c.op)
            lps_pkg::OP_TICK:
            begin
                if (ms_since_step != lps_pkg::ELAPSED_MAX)
                    ms_since_step = ms_since_step + 1'b1;
                if (int'(ms_since_step) > lim)
                begin
                    ms_since_step = '0;
                    advance_pattern();
                    r.stepped = 1'b1;
                end
            end
            lps_pkg::OP_NEXT:
            begin
                led_state   = '0;
                pattern_sel = pattern_sel + 2'd1;
            end
            lps_pkg::OP_FASTER:
                if (int'(speed_sel) + 1 < USABLE_LEVELS)
                    speed_sel = speed_sel + 2'd1;
            lps_pkg::OP_SLOWER:
                if (speed_sel != 2'd0)
                    speed_sel = speed_sel - 2'd1;
            lps_pkg::OP_SET:
                if (int'(c.speed_value) < USABLE_LEVELS)
                    speed_sel = c.speed_value[1:0];
                else
                    r.bad_speed = 1'b1;
            default:
                ;
        endcase
        r.leds        = led_state;
        r.mode        = pattern_sel;
        r.speed_level = speed_sel;
        return r;
    endfunction

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] speed_value);
        lps_pkg::cmd_item_t c;
        int                 gap;
        c.op          = op;
        c.speed_value = speed_value;
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (cmd_stall);
        expected_displays.push_back(next_display(c));
        cmd_count++;
        @(negedge clk);
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (expected_displays.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_config(input logic [15:0] iv0, iv1, iv2, iv3, seed);
        logic [2:0]  reg_index [5];
        logic [15:0] reg_value [5];
        reg_index = '{lps_pkg::CFG_INTERVAL0, lps_pkg::CFG_INTERVAL1,
                      lps_pkg::CFG_INTERVAL2, lps_pkg::CFG_INTERVAL3, lps_pkg::CFG_SEED};
        reg_value = '{iv0, iv1, iv2, iv3, seed};
        wait_idle();
        for (int k = 0; k < 5; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_index[k];
            cfg_data  <= reg_value[k];
            do
                @(posedge clk);
            while (!cfg_ready);
            if (reg_index[k] == lps_pkg::CFG_SEED)
                lfsr_state = (reg_value[k] == 16'h0000) ? 16'h0001 : reg_value[k];
            else
                step_interval[k] = reg_value[k];
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        config_count++;
    endtask

    task automatic test_reset_state();
        send_cmd(lps_pkg::OP_SHOW, 8'h00);
        send_cmd(OP_SPARE6, 8'hFF);
        send_cmd(OP_SPARE7, 8'h5A);
    endtask

    task automatic test_speed_commands();
        repeat (4) send_cmd(lps_pkg::OP_FASTER, 8'h00);
        repeat (4) send_cmd(lps_pkg::OP_SLOWER, 8'hFF);
        send_cmd(lps_pkg::OP_SET, 8'd3);
        send_cmd(lps_pkg::OP_SET, 8'd4);
        send_cmd(lps_pkg::OP_SET, 8'd255);
        send_cmd(lps_pkg::OP_SET, 8'd0);
    endtask

    // zero interval steps on every tick; zero seed must load as one
    task automatic test_every_mode_stepping();
        load_config(16'd0, 16'd500, 16'd250, 16'd100, 16'd0);
        repeat (3) send_cmd(lps_pkg::OP_TICK, 8'h00);
        send_cmd(lps_pkg::OP_NEXT, 8'h00);
        send_cmd(lps_pkg::OP_TICK, 8'h00);
        send_cmd(lps_pkg::OP_NEXT, 8'h00);
        send_cmd(lps_pkg::OP_TICK, 8'h00);
        send_cmd(lps_pkg::OP_NEXT, 8'h00);
        repeat (2) send_cmd(lps_pkg::OP_TICK, 8'h00);
    endtask

    task automatic random_command();
        int         r;
        logic [7:0] sv;
        r  = $urandom_range(0, 99);
        sv = 8'($urandom_range(0, 255));
        if (r < 82)
            send_cmd(lps_pkg::OP_TICK, sv);
        else if (r < 84)
            send_cmd(lps_pkg::OP_NEXT, sv);
        else if (r < 88)
            send_cmd(lps_pkg::OP_FASTER, sv);
        else if (r < 92)
            send_cmd(lps_pkg::OP_SLOWER, sv);
        else if (r < 97)
            send_cmd(lps_pkg::OP_SET, $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : sv);
        else if (r < 98)
            send_cmd(lps_pkg::OP_SHOW, sv);
        else
            send_cmd($urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7, sv);
    endtask

    function automatic logic [15:0] random_interval();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 4));
    endfunction

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
                load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (p == 1)
                load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            else
                load_config(random_interval(), random_interval(), random_interval(),
                            random_interval(), 16'($urandom_range(0, 65535)));
            idle_on = (p != 3);
            repeat (PHASE_CMDS) random_command();
        end
    endtask

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                res_stall <= 1'b1;
                repeat (pick_gap() + 1) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        lps_pkg::res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_displays.size() == 0)
            begin
                err_count++;
                $error("result transfer with no command outstanding: %h", res);
            end
            else
            begin
                want = expected_displays.pop_front();
                if (res.stepped === 1'b1)
                    step_count++;
                if (res.leds !== want.leds)
                begin
                    err_count++;
                    $error("leds: expected %h, got %h", want.leds, res.leds);
                end
                if (res.mode !== want.mode)
                begin
                    err_count++;
                    $error("mode: expected %0d, got %0d", want.mode, res.mode);
                end
                if (res.speed_level !== want.speed_level)
                begin
                    err_count++;
                    $error("speed_level: expected %0d, got %0d", want.speed_level,
                           res.speed_level);
                end
                if (res.bad_speed !== want.bad_speed)
                begin
                    err_count++;
                    $error("bad_speed: expected %b, got %b", want.bad_speed, res.bad_speed);
                end
                if (res.stepped !== want.stepped)
                begin
                    err_count++;
                    $error("stepped: expected %b, got %b", want.stepped, res.stepped);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_CYCLES);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_on      = 1'b0;
        err_count    = 0;
        cmd_count    = 0;
        step_count   = 0;
        config_count = 0;
        quiet_cycles = 0;
        reset_predictor();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        idle_on = 1'b1;

        test_reset_state();
        test_speed_commands();
        test_every_mode_stepping();
        test_random_traffic();

        wait_idle();
        $display("Run covered %0d commands over %0d register settings, %0d pattern steps.",
                 cmd_count, config_count, step_count);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
